FILE: rtl/core/gilc_pkg.sv
`default_nettype none
package gilc_pkg;

    localparam int MAX_DIM_DEFAULT   = 128;
    localparam int MAX_REACH_DEFAULT = 15;
    localparam logic [7:0] THRESHOLD_RESET = 8'd50;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH   = 3'd0,
        CFG_GRID_HEIGHT  = 3'd1,
        CFG_THRESHOLD    = 3'd2,
        CFG_ALLOW_UNKN   = 3'd3,
        CFG_REACH        = 3'd4,
        CFG_RADIUS_SQ    = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK,
        ST_Q_RD,
        ST_Q_CHK
    } state_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/grid_inflate_and_line_check_core.sv
`default_nettype none
// Occupancy grid inflation and segment line-of-sight core. Map cells are
// loaded one item per cycle in raster order while the input is not stalled;
// the item flagged last_cell starts a rebuild that sweeps the whole inflated
// bitmap clear (the same pass that runs once after reset), then visits every
// grid cell through the scan read and check states and, for each occupied
// one, walks its (2*reach+1)^2 offsets in the mark state, at most one bitmap
// write per cycle through the single write port. A query walks its Bresenham
// line with one bitmap read per cell, through a read state and a check state
// for each cell, and ends early at the first blocked cell. Input stall is
// high while any of this runs and while a result waits to be taken.
module grid_inflate_and_line_check_core
#(
    parameter int MAX_DIM   = gilc_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_REACH = gilc_pkg::MAX_REACH_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic signed [7:0]             cell_value,
    input  wire logic                          last_cell,
    input  wire logic [7:0]                    start_x,
    input  wire logic [7:0]                    start_y,
    input  wire logic [7:0]                    end_x,
    input  wire logic [7:0]                    end_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               path_free,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gilc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import gilc_pkg::*;

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = ADDR_W + 1;
    localparam int R_W    = $clog2(MAX_REACH + 1);
    localparam int OFF_W  = R_W + 1;
    localparam int N_W    = DIM_W + 2;
    localparam int SQ_W   = 2 * OFF_W + 10;
    localparam int ERR_W  = 12;

    // Configuration registers.
    logic [7:0]  grid_width_reg, grid_height_reg, threshold_reg;
    logic        allow_unknown_reg;
    logic [3:0]  reach_reg;
    logic [15:0] radius_sq_reg;

    logic cfg_we;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= '0;
            grid_height_reg   <= '0;
            threshold_reg     <= THRESHOLD_RESET;
            allow_unknown_reg <= 1'b0;
            reach_reg         <= '0;
            radius_sq_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg    <= cfg_data[7:0];
                CFG_GRID_HEIGHT: grid_height_reg   <= cfg_data[7:0];
                CFG_THRESHOLD:   threshold_reg     <= cfg_data[7:0];
                CFG_ALLOW_UNKN:  allow_unknown_reg <= cfg_data[0];
                CFG_REACH:       reach_reg         <= cfg_data[3:0];
                CFG_RADIUS_SQ:   radius_sq_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective dimensions and reach, clamped to the storage size.
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [R_W-1:0]   reach_eff;
    always_comb
    begin
        w_eff = (32'(grid_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM)
                                                : DIM_W'(grid_width_reg);
        h_eff = (32'(grid_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM)
                                                 : DIM_W'(grid_height_reg);
        reach_eff = (32'(reach_reg) > MAX_REACH) ? R_W'(MAX_REACH)
                                                 : R_W'(reach_reg);
    end

    state_t state_reg, state_next;

    logic [POS_W-1:0]       load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                   rebuild_reg, rebuild_next;
    logic [IDX_W-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic signed [OFF_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [7:0]             qx_reg, qx_next, qy_reg, qy_next;
    logic [7:0]             qx1_reg, qx1_next, qy1_reg, qy1_next;
    logic signed [ERR_W-1:0] err_reg, err_next, dx_reg, dx_next, dy_reg, dy_next;
    logic                   qsx_reg, qsx_next, qsy_reg, qsy_next;
    logic                   inb_reg, inb_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   path_free_reg, path_free_next;

    logic occ_mem  [CELLS];
    logic infl_mem [CELLS];
    logic occ_rd_reg, infl_rd_reg;

    logic in_acc;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign path_free = path_free_reg;

    // Classification of the loaded cell.
    logic occ_class;
    assign occ_class = (cell_value < 0) ? !allow_unknown_reg
                                        : (cell_value[6:0] >= threshold_reg);

    // Shared cell address unit: y*width + x.
    logic [IDX_W-1:0]  ax, ay;
    logic [ADDR_W-1:0] cell_addr;
    assign cell_addr = ADDR_W'(ay * w_eff + ADDR_W'(ax));

    // Mark step: neighbor position and squared distance.
    logic signed [N_W-1:0] nx, ny;
    logic [SQ_W-1:0]       d2;
    logic                  n_in_grid, n_in_disc, mark_last;
    always_comb
    begin
        nx = signed'(N_W'(sx_reg)) + N_W'(ox_reg);
        ny = signed'(N_W'(sy_reg)) + N_W'(oy_reg);
        d2 = SQ_W'(unsigned'(SQ_W'(ox_reg * ox_reg) + SQ_W'(oy_reg * oy_reg))) << 8;
        n_in_grid = (nx >= 0) && (ny >= 0) && (nx < signed'(N_W'(w_eff)))
                    && (ny < signed'(N_W'(h_eff)));
        n_in_disc = d2 <= SQ_W'(radius_sq_reg);
        mark_last = (ox_reg == signed'(OFF_W'(reach_eff)))
                    && (oy_reg == signed'(OFF_W'(reach_eff)));
    end

    logic scan_last_x, scan_last;
    assign scan_last_x = (DIM_W'(sx_reg) == w_eff - 1'b1);
    assign scan_last   = scan_last_x && (DIM_W'(sy_reg) == h_eff - 1'b1);

    // Query step values.
    logic signed [ERR_W:0] e2;
    logic q_at_end;
    assign e2       = {err_reg, 1'b0};
    assign q_at_end = (qx_reg == qx1_reg) && (qy_reg == qy1_reg);

    // Address selection.
    always_comb
    begin
        if (state_reg == ST_MARK)
        begin
            ax = IDX_W'(nx);
            ay = IDX_W'(ny);
        end
        else if (state_reg == ST_Q_RD)
        begin
            ax = qx_reg[IDX_W-1:0];
            ay = qy_reg[IDX_W-1:0];
        end
        else
        begin
            ax = sx_reg;
            ay = sy_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == ADDR_W'(CELLS - 1))
                begin
                    if (rebuild_reg && (w_eff != '0) && (h_eff != '0))
                        state_next = ST_SCAN_RD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_QUERY)
                        state_next = ST_Q_RD;
                    else if (last_cell)
                        state_next = ST_CLEAR;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (occ_rd_reg)
                    state_next = ST_MARK;
                else
                    state_next = scan_last ? ST_IDLE : ST_SCAN_RD;
            end
            ST_MARK:
            begin
                if (mark_last)
                    state_next = scan_last ? ST_IDLE : ST_SCAN_RD;
            end
            ST_Q_RD: state_next = ST_Q_CHK;
            ST_Q_CHK:
            begin
                if (!inb_reg || infl_rd_reg || q_at_end)
                    state_next = ST_IDLE;
                else
                    state_next = ST_Q_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        load_pos_next  = load_pos_reg;
        clr_idx_next   = clr_idx_reg;
        rebuild_next   = rebuild_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qx1_next       = qx1_reg;
        qy1_next       = qy1_reg;
        err_next       = err_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        qsx_next       = qsx_reg;
        qsy_next       = qsy_reg;
        inb_next       = inb_reg;
        out_valid_next = out_valid_reg && out_stall;
        path_free_next = path_free_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                sx_next      = '0;
                sy_next      = '0;
            end
            ST_IDLE:
            begin
                if (in_acc && (op == OP_LOAD))
                begin
                    if (load_pos_reg < POS_W'(CELLS))
                        load_pos_next = load_pos_reg + 1'b1;
                    if (last_cell)
                    begin
                        load_pos_next = '0;
                        rebuild_next  = 1'b1;
                        clr_idx_next  = '0;
                    end
                end
                else if (in_acc)
                begin
                    qx_next  = start_x;
                    qy_next  = start_y;
                    qx1_next = end_x;
                    qy1_next = end_y;
                    dx_next  = (end_x > start_x) ? ERR_W'(end_x - start_x)
                                                 : ERR_W'(start_x - end_x);
                    dy_next  = (end_y > start_y) ? -ERR_W'(end_y - start_y)
                                                 : -ERR_W'(start_y - end_y);
                    err_next = ((end_x > start_x) ? ERR_W'(end_x - start_x)
                                                  : ERR_W'(start_x - end_x))
                             - ((end_y > start_y) ? ERR_W'(end_y - start_y)
                                                  : ERR_W'(start_y - end_y));
                    qsx_next = start_x < end_x;
                    qsy_next = start_y < end_y;
                end
            end
            ST_SCAN_CHK:
            begin
                ox_next = -signed'(OFF_W'(reach_eff));
                oy_next = -signed'(OFF_W'(reach_eff));
                if (!occ_rd_reg)
                begin
                    sx_next = scan_last_x ? '0 : sx_reg + 1'b1;
                    sy_next = scan_last_x ? sy_reg + 1'b1 : sy_reg;
                end
            end
            ST_MARK:
            begin
                if (ox_reg == signed'(OFF_W'(reach_eff)))
                begin
                    ox_next = -signed'(OFF_W'(reach_eff));
                    oy_next = oy_reg + 1'b1;
                end
                else
                    ox_next = ox_reg + 1'b1;
                if (mark_last)
                begin
                    sx_next = scan_last_x ? '0 : sx_reg + 1'b1;
                    sy_next = scan_last_x ? sy_reg + 1'b1 : sy_reg;
                end
            end
            ST_Q_RD:
            begin
                inb_next = (9'(qx_reg) < 9'(w_eff)) && (9'(qy_reg) < 9'(h_eff));
            end
            ST_Q_CHK:
            begin
                if (!inb_reg || infl_rd_reg)
                begin
                    out_valid_next = 1'b1;
                    path_free_next = 1'b0;
                end
                else if (q_at_end)
                begin
                    out_valid_next = 1'b1;
                    path_free_next = 1'b1;
                end
                else
                begin
                    err_next = err_reg
                             + ((e2 >= (ERR_W+1)'(dy_reg)) ? dy_reg : '0)
                             + ((e2 <= (ERR_W+1)'(dx_reg)) ? dx_reg : '0);
                    if (e2 >= (ERR_W+1)'(dy_reg))
                        qx_next = qsx_reg ? qx_reg + 1'b1 : qx_reg - 1'b1;
                    if (e2 <= (ERR_W+1)'(dx_reg))
                        qy_next = qsy_reg ? qy_reg + 1'b1 : qy_reg - 1'b1;
                end
            end
            default: ;
        endcase
        if (state_next == ST_IDLE && state_reg != ST_IDLE)
            rebuild_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            load_pos_reg  <= '0;
            clr_idx_reg   <= '0;
            rebuild_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            clr_idx_reg   <= clr_idx_next;
            rebuild_reg   <= rebuild_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qx1_reg       <= qx1_next;
        qy1_reg       <= qy1_next;
        err_reg       <= err_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        qsx_reg       <= qsx_next;
        qsy_reg       <= qsy_next;
        inb_reg       <= inb_next;
        path_free_reg <= path_free_next;
    end

    // Occupancy store: written on loads, read during the scan.
    always_ff @(posedge clk)
    begin
        if (in_acc && (op == OP_LOAD) && (load_pos_reg < POS_W'(CELLS)))
            occ_mem[load_pos_reg[ADDR_W-1:0]] <= occ_class;
        occ_rd_reg <= occ_mem[cell_addr];
    end

    // Inflated bitmap: cleared by sweep, marked per neighbor, read by queries.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            infl_mem[clr_idx_reg] <= 1'b0;
        else if ((state_reg == ST_MARK) && n_in_grid && n_in_disc)
            infl_mem[cell_addr] <= 1'b1;
        infl_rd_reg <= infl_mem[cell_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/gilc_checker.sv
`default_nettype none
module gilc_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic op,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic path_free
);
    import gilc_pkg::*;

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(path_free))
        else $error("result changed while stalled");

    // A query keeps the core busy on the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_QUERY) |=> in_stall)
        else $error("core took a new item right after a query");

    // No result can appear the cycle after a query is taken.
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_QUERY) |=> !out_valid)
        else $error("result appeared too early");

    // The input side is stalled whenever a result waits.
    a_stall_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while a result waits");

endmodule

bind grid_inflate_and_line_check_core gilc_checker u_gilc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .path_free (path_free)
);
`default_nettype wire
